[rtl/ppmh_pkg.sv]
// ----------------------------------------------------------------------------
// ppmh_pkg
// Shared types, constants and helper functions for the per-position
// substitution histogram.
// ----------------------------------------------------------------------------
package ppmh_pkg;

    localparam int READ_POSITIONS = 1024;
    localparam int POS_W          = $clog2(READ_POSITIONS);
    localparam int IDX_W          = POS_W + 1;
    localparam int BASE_CODES     = 5;
    localparam int CNT_DEPTH      = 2 * READ_POSITIONS * BASE_CODES * BASE_CODES;
    localparam int ADDR_W         = $clog2(CNT_DEPTH);
    localparam int CNT_W          = 32;

    localparam logic [CNT_W-1:0] COUNTER_MAX = '1;

    // Operation codes.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BASE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OFFSETS  = 3'd1;
    localparam logic [2:0] ST_PAST_END = 3'd2;
    localparam logic [2:0] ST_TOO_LONG = 3'd3;
    localparam logic [2:0] ST_IGNORED  = 3'd4;

    localparam logic [2:0] CODE_N = 3'd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_UPDATE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic mem_read;
        logic update;
        logic clear_step;
    } t_cmd;

    typedef struct packed {
        logic need_mem;
        logic clear_done;
    } t_stat;

    // Map a character to its 5-level base code.
    function automatic logic [2:0] base_code(input logic [7:0] b);
        logic [2:0] c;
        case (b)
            8'h00, "0", "A", "a": c = 3'd0;
            8'h01, "1", "C", "c": c = 3'd1;
            8'h02, "2", "G", "g": c = 3'd2;
            8'h03, "3", "T", "t": c = 3'd3;
            default:              c = CODE_N;
        endcase
        return c;
    endfunction

    // Flat counter address for (strand, position, ref code, read code).
    function automatic logic [ADDR_W-1:0] cell_addr(input logic s,
                                                    input logic [POS_W-1:0] pos,
                                                    input logic [2:0] r,
                                                    input logic [2:0] c);
        logic [ADDR_W-1:0] a;
        a = s ? ADDR_W'(READ_POSITIONS * BASE_CODES * BASE_CODES) : '0;
        a = a + ADDR_W'(pos) * ADDR_W'(BASE_CODES * BASE_CODES);
        a = a + ADDR_W'(r) * ADDR_W'(BASE_CODES) + ADDR_W'(c);
        return a;
    endfunction

endpackage

[rtl/ppmh_ram.sv]
// ----------------------------------------------------------------------------
// ppmh_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ppmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ppmh_ctrl.sv]
// ----------------------------------------------------------------------------
// ppmh_ctrl
// Sequencer: clearing pass after reset, then one command at a time through
// execute, optional memory read and update, and a one-cycle result strobe.
// ----------------------------------------------------------------------------
module ppmh_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  ppmh_pkg::t_stat i_stat,
    output ppmh_pkg::t_cmd  o_cmd,
    output logic           busy,
    output logic           o_valid
);
    import ppmh_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (i_stat.clear_done) n_state = S_IDLE;
            S_IDLE:   if (start) n_state = S_EXEC;
            S_EXEC:   n_state = i_stat.need_mem ? S_READ : S_DONE;
            S_READ:   n_state = S_UPDATE;
            S_UPDATE: n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        busy             = 1'b1;
        o_valid          = 1'b0;
        case (r_state)
            S_CLEAR:  o_cmd.clear_step = 1'b1;
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_EXEC:   o_cmd.exec = 1'b1;
            S_READ:   o_cmd.mem_read = 1'b1;
            S_UPDATE: o_cmd.update = 1'b1;
            S_DONE:   o_valid = 1'b1;
            default:  busy = 1'b1;
        endcase
    end

    // A command is only taken in the idle state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == S_IDLE))
        else $error("load command outside idle");

    // A memory access always leads to the update step and then the strobe.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mem_read |=> o_cmd.update ##1 o_valid)
        else $error("memory read not followed by update and result");

endmodule

[rtl/ppmh_dp.sv]
// ----------------------------------------------------------------------------
// ppmh_dp
// Datapath: command registers, read tracking, range checks, counter address,
// saturating increment and the counter memory with its clearing sweep.
// ----------------------------------------------------------------------------
module ppmh_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ppmh_pkg::t_cmd          i_cmd,
    output ppmh_pkg::t_stat         o_stat,
    input  logic [1:0]             i_op,
    input  logic signed [1:0]      i_strand,
    input  logic [30:0]            i_read_start,
    input  logic [30:0]            i_read_end,
    input  logic [15:0]            i_read_length,
    input  logic [30:0]            i_contig_length,
    input  logic [7:0]             i_ref_byte,
    input  logic [7:0]             i_read_byte,
    input  logic [9:0]             i_query_position,
    input  logic [2:0]             i_query_ref_code,
    input  logic [2:0]             i_query_read_code,
    output logic [2:0]             o_status,
    output logic [ppmh_pkg::CNT_W-1:0] o_count_value,
    output logic [15:0]            o_longest_read
);
    import ppmh_pkg::*;

    // Latched command.
    logic [1:0]        r_op;
    logic [1:0]        r_strand;
    logic [30:0]       r_start;
    logic [30:0]       r_end;
    logic [15:0]       r_len;
    logic [30:0]       r_contig;
    logic [2:0]        r_ref_code;
    logic [2:0]        r_read_code;
    logic [9:0]        r_qpos;
    logic [2:0]        r_qref;
    logic [2:0]        r_qread;

    // Read tracking.
    logic              r_active;
    logic              r_astrand;
    logic [IDX_W-1:0]  r_bidx;
    logic [IDX_W-1:0]  r_alen;
    logic [15:0]       r_max;

    // Result and memory access.
    logic [2:0]        r_status;
    logic [CNT_W-1:0]  r_count;
    logic              r_is_inc;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_clr_addr;

    logic [31:0]       sum_sl;
    logic [31:0]       end_p1;
    logic [31:0]       contig_x;
    logic [31:0]       start_x;
    logic              base_ok;
    logic              query_ok;
    logic [2:0]        start_status;
    logic              start_ok;
    logic [ADDR_W-1:0] n_addr;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CNT_W-1:0]  mem_wdata;
    logic [CNT_W-1:0]  mem_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_op;
            r_strand    <= i_strand;
            r_start     <= i_read_start;
            r_end       <= i_read_end;
            r_len       <= i_read_length;
            r_contig    <= i_contig_length;
            r_ref_code  <= base_code(i_ref_byte);
            r_read_code <= base_code(i_read_byte);
            r_qpos      <= i_query_position;
            r_qref      <= i_query_ref_code;
            r_qread     <= i_query_read_code;
        end
    end

    // Start-of-read checks, in priority order.
    assign start_x  = {1'b0, r_start};
    assign contig_x = {1'b0, r_contig};
    assign sum_sl   = start_x + {16'b0, r_len};
    assign end_p1   = {1'b0, r_end} + 32'd1;

    always_comb begin
        start_status = ST_OK;
        if (sum_sl != end_p1) begin
            start_status = ST_OFFSETS;
        end else if (sum_sl >= contig_x || start_x > contig_x) begin
            start_status = ST_PAST_END;
        end else if ({16'b0, r_len} > 32'(READ_POSITIONS)) begin
            start_status = ST_TOO_LONG;
        end
    end

    // A negative strand skips the read without any check.
    assign start_ok = !r_strand[1] && (start_status == ST_OK);
    assign base_ok  = r_active && (r_bidx < r_alen);
    assign query_ok = !r_strand[1] && (32'(r_qpos) < 32'(READ_POSITIONS)) &&
                      (r_qref <= CODE_N) && (r_qread <= CODE_N);

    always_comb begin
        if (r_op == OP_BASE) begin
            n_addr = cell_addr(r_astrand, r_bidx[POS_W-1:0], r_ref_code, r_read_code);
        end else begin
            n_addr = cell_addr(r_strand[0], POS_W'(r_qpos), r_qref, r_qread);
        end
    end

    assign o_stat.need_mem   = ((r_op == OP_BASE) && base_ok) ||
                               ((r_op == OP_QUERY) && query_ok);
    assign o_stat.clear_done = (r_clr_addr == ADDR_W'(CNT_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_astrand  <= 1'b0;
            r_bidx     <= '0;
            r_alen     <= '0;
            r_max      <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.exec) begin
                case (r_op)
                    OP_START: begin
                        if (r_len > r_max) begin
                            r_max <= r_len;
                        end
                        r_active <= start_ok;
                        if (start_ok) begin
                            r_astrand <= r_strand[0];
                            r_bidx    <= '0;
                            r_alen    <= IDX_W'(r_len);
                        end
                    end
                    OP_BASE: begin
                        if (base_ok) begin
                            r_bidx <= r_bidx + 1'b1;
                        end
                    end
                    default: r_active <= r_active;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_count  <= '0;
            r_addr   <= n_addr;
            r_is_inc <= (r_op == OP_BASE);
            case (r_op)
                OP_START: r_status <= r_strand[1] ? ST_OK : start_status;
                OP_BASE:  r_status <= base_ok ? ST_OK : ST_IGNORED;
                OP_QUERY: r_status <= query_ok ? ST_OK : ST_IGNORED;
                default:  r_status <= ST_IGNORED;
            endcase
        end
        if (i_cmd.update && !r_is_inc) begin
            r_count <= mem_rdata;
        end
    end

    // The write port serves the clearing sweep and the saturating increment.
    assign mem_we    = i_cmd.clear_step || (i_cmd.update && r_is_inc);
    assign mem_waddr = i_cmd.clear_step ? r_clr_addr : r_addr;
    assign mem_wdata = i_cmd.clear_step ? '0 :
                       (mem_rdata == COUNTER_MAX) ? mem_rdata : mem_rdata + 1'b1;

    ppmh_ram #(
        .WIDTH (CNT_W),
        .DEPTH (CNT_DEPTH)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (i_cmd.mem_read),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    assign o_status       = r_status;
    assign o_count_value  = r_count;
    assign o_longest_read = r_max;

    // The base index never runs past the length of the open read.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_bidx <= r_alen))
        else $error("base index beyond read length");

    // An open read never exceeds the position table.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (32'(r_alen) <= 32'(READ_POSITIONS)))
        else $error("active read longer than position table");

endmodule

[rtl/per_position_mismatch_histogram.sv]
// ----------------------------------------------------------------------------
// per_position_mismatch_histogram
// Per-strand, per-position substitution counter between reference and read
// bases, with read start checks and counter readback.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 51200-entry counter memory to zero, one
// entry per cycle, holding busy high during the sweep. It then takes one
// command whenever busy is low and stays busy through that command's result
// strobe. A start-read command, an unused op, a base pair with no open read
// position left or an invalid counter query goes from the execute step
// straight to its result strobe. A counted base pair or a valid counter
// query goes through the single counter memory (a registered read, then the
// saturating write-back for a base pair or the count capture for a query)
// before it strobes. Each result appears for exactly one cycle on o_valid
// and is not held; the receiver must take it then.
module per_position_mismatch_histogram (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_op,
    input  logic signed [1:0]    i_strand,
    input  logic [30:0]          i_read_start,
    input  logic [30:0]          i_read_end,
    input  logic [15:0]          i_read_length,
    input  logic [30:0]          i_contig_length,
    input  logic [7:0]           i_ref_byte,
    input  logic [7:0]           i_read_byte,
    input  logic [9:0]           i_query_position,
    input  logic [2:0]           i_query_ref_code,
    input  logic [2:0]           i_query_read_code,
    output logic                 o_valid,
    output logic [2:0]           o_status,
    output logic [31:0]          o_count_value,
    output logic [15:0]          o_longest_read
);
    import ppmh_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ppmh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    ppmh_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_op              (i_op),
        .i_strand          (i_strand),
        .i_read_start      (i_read_start),
        .i_read_end        (i_read_end),
        .i_read_length     (i_read_length),
        .i_contig_length   (i_contig_length),
        .i_ref_byte        (i_ref_byte),
        .i_read_byte       (i_read_byte),
        .i_query_position  (i_query_position),
        .i_query_ref_code  (i_query_ref_code),
        .i_query_read_code (i_query_read_code),
        .o_status          (o_status),
        .o_count_value     (o_count_value),
        .o_longest_read    (o_longest_read)
    );

    // Each result beat lasts exactly one cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // A taken command keeps the block busy until its result beat.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after taking a command");

    // Only a successful query returns a nonzero count.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_count_value == '0))
        else $error("nonzero count with a failing status");

endmodule
